// ===== rtl/core/rtpst_pkg.sv =====
// Package for the RTP retransmission slot table: codes, stream layouts and
// the command and status types shared by the front, queue, back and top.
// Depends on nothing.
`default_nettype none

package rtpst_pkg;

	localparam int SLOTS_DEFAULT = 64;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 7'd64;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_COPY = 2'd2;
	localparam logic [1:0] FUNC_REMOVE = 2'd3;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_ZERO_LEN = 2'd2,
		ST_TOO_SMALL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_ZERO_LEN,
		OP_LOOKUP,
		OP_COPY,
		OP_REMOVE
	} op_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SCAN,
		BK_FILL_RD,
		BK_FILL_WR,
		BK_RESP
	} back_state_t;

	// Input item payload, last field in the lowest bits.
	typedef struct packed {
		logic [15:0] dest_capacity;
		logic [15:0] packet_length;
		logic [31:0] packet_handle;
		logic [15:0] seq_num;
	} in_data_t;

	// Result item payload, padded to whole bytes.
	typedef struct packed {
		logic        fill;
		logic [6:0]  occupancy;
		logic [15:0] found_length;
		logic [31:0] found_handle;
	} out_data_t;

	localparam int IN_DATA_W = $bits(in_data_t);
	localparam int OUT_DATA_W = $bits(out_data_t);

	typedef struct packed {
		op_t         op;
		logic [15:0] seq_num;
		logic [31:0] packet_handle;
		logic [15:0] packet_length;
		logic [15:0] dest_capacity;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic idle;
	} back_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rtpst_front.sv =====
// Front part of the slot table: accepts input items, classifies the
// operation and hands a command to the queue. Depends on rtpst_pkg.
`default_nettype none

module rtpst_front
	import rtpst_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic [1:0]           s_tuser,
	input  wire back_stat_t           stat,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output cmd_t                      push_cmd
);

	in_data_t din;
	cmd_t cmd_d;
	cmd_t cmd_s1;
	logic vld_s1;
	logic take;

	assign din = in_data_t'(s_tdata);
	assign s_tready = !stat.clearing && (!vld_s1 || push_ready);
	assign take = s_tvalid && s_tready;

	always_comb begin
		cmd_d.seq_num = din.seq_num;
		cmd_d.packet_handle = din.packet_handle;
		cmd_d.packet_length = din.packet_length;
		cmd_d.dest_capacity = din.dest_capacity;
		unique case (s_tuser)
			FUNC_ADD: begin
				cmd_d.op = (din.packet_length == 16'd0) ? OP_ZERO_LEN : OP_ADD;
			end
			FUNC_LOOKUP: begin
				cmd_d.op = OP_LOOKUP;
			end
			FUNC_COPY: begin
				cmd_d.op = OP_COPY;
			end
			FUNC_REMOVE: begin
				cmd_d.op = OP_REMOVE;
			end
			default: begin
				cmd_d.op = OP_LOOKUP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign push_valid = vld_s1;
	assign push_cmd = cmd_s1;

endmodule

`default_nettype wire

// ===== rtl/core/rtpst_queue.sv =====
// Short command queue between the front and the back of the slot table.
// Depends on rtpst_pkg for the command type and the depth.
`default_nettype none

module rtpst_queue
	import rtpst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QW-1:0] LAST_PTR = QW'(QUEUE_DEPTH - 1);
	localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);

	cmd_t entries_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (fill_q != FULL);
	assign pop_valid = (fill_q != '0);
	assign pop_cmd = entries_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rtpst_back.sv =====
// Back part of the slot table: slot memory, sequential key scan, ring
// write pointer, occupancy count, configuration register and result register.
// Depends on rtpst_pkg.
`default_nettype none

module rtpst_back
	import rtpst_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  pop_valid,
	output logic                       pop_ready,
	input  wire cmd_t                  pop_cmd,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output status_t                    m_tuser,
	output back_stat_t                 stat
);

	localparam int AW = $clog2(SLOTS);
	localparam int NW = $clog2(SLOTS + 1);
	localparam int MW = (NW > CFG_W) ? NW : CFG_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);
	localparam logic [MW-1:0] SLOTS_M = MW'(SLOTS);

	typedef struct packed {
		logic        valid;
		logic [15:0] seq_num;
		logic [31:0] packet_handle;
		logic [15:0] packet_length;
	} slot_t;

	slot_t mem [SLOTS];

	back_state_t state_q, state_d;
	logic [CFG_W-1:0] slots_in_use_q;
	logic [AW-1:0] scan_idx_q;
	logic issue_done_q;
	logic [AW-1:0] r_q;
	logic [AW-1:0] wp_q;
	logic [NW-1:0] count_q;
	cmd_t cmd_q;

	logic rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	slot_t rd_data_s1;

	status_t res_status_q, res_status_d;
	logic [31:0] res_handle_q, res_handle_d;
	logic [15:0] res_length_q, res_length_d;

	logic m_tvalid_q;
	out_data_t m_data_q;
	status_t m_status_q;

	logic [MW-1:0] cfg_m;
	logic [MW-1:0] ring_m;
	logic [NW-1:0] ring_n;
	logic [NW-1:0] r_ext;
	logic [NW-1:0] r_next;

	logic rd_en, wr_en, res_load, out_load, wp_load, count_inc, count_dec, pop;
	logic [AW-1:0] rd_addr, wr_addr;
	slot_t wr_data;
	slot_t new_slot;
	logic hit, last;

	// Effective ring size, the register saturated to 1..SLOTS.
	assign cfg_m = MW'(slots_in_use_q);
	always_comb begin
		if (cfg_m == '0) begin
			ring_m = MW'(1);
		end else if (cfg_m > SLOTS_M) begin
			ring_m = SLOTS_M;
		end else begin
			ring_m = cfg_m;
		end
	end
	assign ring_n = NW'(ring_m);
	assign r_ext = NW'(r_q);
	assign r_next = r_ext + 1'b1;

	assign new_slot.valid = 1'b1;
	assign new_slot.seq_num = cmd_q.seq_num;
	assign new_slot.packet_handle = cmd_q.packet_handle;
	assign new_slot.packet_length = cmd_q.packet_length;

	assign hit = rd_vld_s1 && rd_data_s1.valid && (rd_data_s1.seq_num == cmd_q.seq_num);
	assign last = (rd_idx_s1 == LAST_IDX);
	assign pop = pop_valid && pop_ready;

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = scan_idx_q;
		wr_en = 1'b0;
		wr_addr = scan_idx_q;
		wr_data = '0;
		res_load = 1'b0;
		res_status_d = ST_OK;
		res_handle_d = '0;
		res_length_d = '0;
		count_inc = 1'b0;
		count_dec = 1'b0;
		wp_load = 1'b0;
		out_load = 1'b0;
		pop_ready = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				wr_en = 1'b1;
				if (scan_idx_q == LAST_IDX) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					if (pop_cmd.op == OP_ZERO_LEN) begin
						res_load = 1'b1;
						res_status_d = ST_ZERO_LEN;
						state_d = BK_RESP;
					end else begin
						state_d = BK_SCAN;
					end
				end
			end
			BK_SCAN: begin
				rd_en = !issue_done_q;
				if (hit) begin
					wr_addr = rd_idx_s1;
					res_load = 1'b1;
					state_d = BK_RESP;
					unique case (cmd_q.op)
						OP_ADD: begin
							wr_en = 1'b1;
							wr_data = new_slot;
						end
						OP_REMOVE: begin
							wr_en = 1'b1;
							wr_data = rd_data_s1;
							wr_data.valid = 1'b0;
							count_dec = (count_q != '0);
						end
						OP_COPY: begin
							res_length_d = rd_data_s1.packet_length;
							if (cmd_q.dest_capacity < rd_data_s1.packet_length) begin
								res_status_d = ST_TOO_SMALL;
							end else begin
								res_handle_d = rd_data_s1.packet_handle;
							end
						end
						OP_LOOKUP: begin
							res_length_d = rd_data_s1.packet_length;
							res_handle_d = rd_data_s1.packet_handle;
						end
						default: begin
							res_status_d = ST_ZERO_LEN;
						end
					endcase
				end else if (rd_vld_s1 && last) begin
					if (cmd_q.op == OP_ADD) begin
						state_d = BK_FILL_RD;
					end else begin
						res_load = 1'b1;
						res_status_d = ST_NOT_FOUND;
						state_d = BK_RESP;
					end
				end
			end
			BK_FILL_RD: begin
				rd_en = 1'b1;
				rd_addr = r_q;
				state_d = BK_FILL_WR;
			end
			BK_FILL_WR: begin
				wr_en = 1'b1;
				wr_addr = r_q;
				wr_data = new_slot;
				count_inc = !rd_data_s1.valid;
				wp_load = 1'b1;
				res_load = 1'b1;
				state_d = BK_RESP;
			end
			BK_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			slots_in_use_q <= SLOTS_IN_USE_RESET;
			scan_idx_q <= '0;
			issue_done_q <= 1'b0;
			r_q <= '0;
			wp_q <= '0;
			count_q <= '0;
			rd_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= rd_en;
			if (cfg_valid) begin
				slots_in_use_q <= cfg_data;
			end
			if (pop) begin
				scan_idx_q <= '0;
				issue_done_q <= 1'b0;
				r_q <= wp_q;
			end else begin
				if ((state_q == BK_CLEAR) || (state_q == BK_SCAN && rd_en)) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (state_q == BK_SCAN && rd_en && scan_idx_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end
				// The pointer is reduced modulo the ring size while the scan runs.
				if (state_q == BK_SCAN && r_ext >= ring_n) begin
					r_q <= AW'(r_ext - ring_n);
				end
			end
			if (wp_load) begin
				wp_q <= (r_next == ring_n) ? '0 : AW'(r_next);
			end
			if (count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (count_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (pop) begin
			cmd_q <= pop_cmd;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_handle_q <= res_handle_d;
			res_length_q <= res_length_d;
		end
		if (out_load) begin
			m_status_q <= res_status_q;
			m_data_q.fill <= 1'b0;
			m_data_q.occupancy <= 7'(count_q);
			m_data_q.found_length <= res_length_q;
			m_data_q.found_handle <= res_handle_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_status_q;
	assign stat.clearing = (state_q == BK_CLEAR);
	assign stat.idle = (state_q == BK_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/rtp_retransmit_slot_table_core.sv =====
// Top level of the RTP retransmission slot table: front, command queue and
// back. Depends on rtpst_pkg, rtpst_front, rtpst_queue and rtpst_back.
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    s_tdata, s_tuser: one operation
// m_*       out        m_tvalid/m_tready    m_tdata, m_tuser: one result
// cfg_*     in         cfg_valid/cfg_ready  cfg_data: slots_in_use
//
// After reset a clearing pass marks every slot empty; no item
// is taken during it. An item searches the slots one per cycle from the lowest
// index; an add that misses then fills the ring slot at the write pointer, and
// a zero length add is answered without a scan.
// The queue lets the front keep taking items, until it is full, while the back
// scans or its result waits.
`default_nettype none

module rtp_retransmit_slot_table_core
	import rtpst_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// seq_num[15:0], packet_handle[47:16], packet_length[63:48], dest_capacity[79:64]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// found_handle[31:0], found_length[47:32], occupancy[54:48], zero[55]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// status[1:0]
	output logic [1:0]                 m_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	back_stat_t stat;
	logic push_valid, push_ready;
	cmd_t push_cmd;
	logic pop_valid, pop_ready;
	cmd_t pop_cmd;
	status_t status;

	rtpst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.stat       (stat),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	rtpst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	rtpst_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (status),
		.stat      (stat)
	);

	assign m_tuser = status;

	// No item is taken while the slot memory is being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !s_tready)
	else $error("item taken during the clearing pass");

	// The clearing pass runs once after reset and never again.
	assert property (@(posedge clk) disable iff (!arst_n)
		!stat.clearing |=> !stat.clearing)
	else $error("clearing pass restarted without reset");

	// A new result appears only after the back has finished an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!stat.idle && !stat.clearing))
	else $error("result raised without a finished item");

endmodule

`default_nettype wire
